// File: src/life_automaton_row_step_macros.svh
// assertion macros for the row step block
`ifndef LIFE_AUTOMATON_ROW_STEP_MACROS_SVH
`define LIFE_AUTOMATON_ROW_STEP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define LARS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("row step same-cycle check failed");
// next-cycle implication, checked out of reset
`define LARS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("row step next-cycle check failed");
`else
`define LARS_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define LARS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// File: src/lars_pkg.sv
package lars_pkg;

    // fixed field widths
    localparam int ROW_W     = 64;
    localparam int IDX_W     = 10;
    localparam int NROWS_W   = 11;
    localparam int NCOLS_W   = 7;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

    // register reset values
    localparam logic [NROWS_W-1:0] NUM_ROWS_RST = 11'd64;
    localparam logic [NCOLS_W-1:0] NUM_COLS_RST = 7'd64;

    // b3/s23 rule
    localparam logic [3:0] BIRTH_COUNT  = 4'd3;
    localparam logic [3:0] SURVIVE_LOW  = 4'd2;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [ROW_W-1:0] cells;
        logic [IDX_W-1:0] idx;
        logic             done;
    } res_t;

    typedef struct packed {
        logic has_data;
        logic full;
    } q_stat_t;

endpackage

// File: src/lars_cell.sv
module lars_cell
    import lars_pkg::*;
(
    input  logic [7:0] nbr,
    input  logic       alive,
    output logic       next
);

    logic [3:0] count;

    // neighbor population count
    always_comb
    begin
        count = '0;
        for (int i = 0; i < 8; i++)
        begin
            count = count + 4'(nbr[i]);
        end
    end

    // birth on three, survival on two or three
    assign next = alive ? ((count == SURVIVE_LOW) || (count == BIRTH_COUNT))
                        : (count == BIRTH_COUNT);

endmodule

// File: src/lars_row.sv
module lars_row
    import lars_pkg::*;
#(
    parameter int MAX_COLS = 64
)
(
    input  logic [MAX_COLS-1:0] up,
    input  logic [MAX_COLS-1:0] mid,
    input  logic [MAX_COLS-1:0] dn,
    input  logic [NCOLS_W-1:0]  cols,
    output logic [MAX_COLS-1:0] row
);

    logic [MAX_COLS-1:0] live_mask;
    logic [MAX_COLS+1:0] up_pad;
    logic [MAX_COLS+1:0] mid_pad;
    logic [MAX_COLS+1:0] dn_pad;
    logic [MAX_COLS-1:0] lane_out;

    // columns at or beyond the count are dead
    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            live_mask[c] = (NCOLS_W'(c) < cols);
        end
    end

    // dead border on both sides
    assign up_pad  = {1'b0, up  & live_mask, 1'b0};
    assign mid_pad = {1'b0, mid & live_mask, 1'b0};
    assign dn_pad  = {1'b0, dn  & live_mask, 1'b0};

    // one lane per column
    for (genvar c = 0; c < MAX_COLS; c++)
    begin : g_lane
        lars_cell u_cell (
            .nbr   ({up_pad[c+2:c], mid_pad[c+2], mid_pad[c], dn_pad[c+2:c]}),
            .alive (mid_pad[c+1]),
            .next  (lane_out[c])
        );
    end

    // merge lanes, clear dead columns
    assign row = lane_out & live_mask;

endmodule

// File: src/lars_queue.sv
module lars_queue
    import lars_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en0,
    input  res_t    wr_data0,
    input  logic    wr_en1,
    input  res_t    wr_data1,
    input  logic    pop,
    output res_t    rd_data,
    output q_stat_t stat
);

    res_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic [QCNT_W-1:0] n_push;
    logic [QPTR_W-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);
    assign n_push       = QCNT_W'(wr_en0) + QCNT_W'(wr_en1);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + n_push - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // result storage, up to two writes per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en0)
        begin
            mem_reg[wr_ptr_reg] <= wr_data0;
        end
        if (wr_en1)
        begin
            mem_reg[wr_ptr_plus1] <= wr_data1;
        end
    end

    assign rd_data       = mem_reg[rd_ptr_reg];
    assign stat.has_data = (cnt_reg != '0);
    // keep room for two results of one input beat
    assign stat.full     = (cnt_reg > QCNT_W'(QUEUE_DEPTH - 2));

endmodule

// File: src/life_automaton_row_step.sv
// One generation of the b3/s23 automaton, streamed one row at a time.
// Input channel (in_valid/in_stall) carries one row of cells per beat, top row
// first; bit c is column c. Output channel (out_valid/out_stall) carries one
// next-generation row per beat with its row number and a flag on the last row.
// Row r of the input yields next row r-1; the final row also yields the last
// next row, so on multi-row grids that beat produces two output beats. Rows outside
// the grid and columns at or beyond num_cols are dead; those columns come out zero.
// Configuration: cfg_valid/cfg_ready write num_rows (index 0) or num_cols
// (index 1); cfg_ready is always high. Write only while no beat is in flight;
// a write in mid-generation applies from the next row on.
// Each result is registered in the result queue as its input beat is accepted.
// Throughput: one input beat per cycle while in_stall is low; all columns
// are updated in parallel by one lane per column, two lane rows working
// side by side. The output rate of one beat per cycle sets the pace: the
// final row of a generation yields one extra output beat.
// A four-entry result queue parts the two sides; in_stall rises only when it
// lacks room for two results, so a stalled output backs up into the input.
// Reset empties the queue, clears the stored rows and row count, and sets
// num_rows and num_cols to 64.
`include "life_automaton_row_step_macros.svh"

module life_automaton_row_step
    import lars_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [NROWS_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [ROW_W-1:0]     row_cells,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ROW_W-1:0]     next_row_cells,
    output logic [IDX_W-1:0]     out_row_index,
    output logic                 generation_done
);

    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int CW    = ((CNT_W > NROWS_W) ? CNT_W : NROWS_W) + 1;

    logic [NROWS_W-1:0]  num_rows_reg;
    logic [NCOLS_W-1:0]  num_cols_reg;
    logic [MAX_COLS-1:0] row_above_reg;
    logic [MAX_COLS-1:0] row_above_next;
    logic [MAX_COLS-1:0] row_mid_reg;
    logic [MAX_COLS-1:0] row_mid_next;
    logic [CNT_W-1:0]    rows_seen_reg;
    logic [CNT_W-1:0]    rows_seen_next;

    logic [CW-1:0]       eff_rows;
    logic [NCOLS_W-1:0]  eff_cols;
    logic [CW-1:0]       r_ext;
    logic [CW-1:0]       r_plus1;
    logic [CW-1:0]       r_minus1;
    logic                last_row;
    logic                in_acc;
    logic                push_body;
    logic                push_tail;
    logic [MAX_COLS-1:0] col_mask;
    logic [MAX_COLS-1:0] cur_row;
    logic [MAX_COLS-1:0] body_row;
    logic [MAX_COLS-1:0] tail_row;
    res_t                body_res;
    res_t                tail_res;
    res_t                head_res;
    q_stat_t             q_stat;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= NUM_ROWS_RST;
            num_cols_reg <= NUM_COLS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NUM_ROWS: num_rows_reg <= cfg_data;
                REG_NUM_COLS: num_cols_reg <= cfg_data[NCOLS_W-1:0];
                default:      num_rows_reg <= num_rows_reg;
            endcase
        end
    end

    // effective counts: zero reads as one, saturate at the maximum
    always_comb
    begin
        if (num_rows_reg == '0)
            eff_rows = CW'(1);
        else if (CW'(num_rows_reg) > CW'(MAX_ROWS))
            eff_rows = CW'(MAX_ROWS);
        else
            eff_rows = CW'(num_rows_reg);

        if (num_cols_reg == '0)
            eff_cols = NCOLS_W'(1);
        else if (num_cols_reg > NCOLS_W'(MAX_COLS))
            eff_cols = NCOLS_W'(MAX_COLS);
        else
            eff_cols = num_cols_reg;
    end

    // dead columns of the incoming row are cleared before use and storage
    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_mask[c] = (NCOLS_W'(c) < eff_cols);
        end
    end

    // row position within the generation
    assign in_acc   = in_valid && !in_stall;
    assign r_ext    = CW'(rows_seen_reg);
    assign r_plus1  = r_ext + CW'(1);
    assign r_minus1 = r_ext - CW'(1);
    assign last_row = (r_plus1 >= eff_rows);
    assign cur_row  = row_cells[MAX_COLS-1:0] & col_mask;

    // lane rows: the row above the input, and the input row itself as the closing row
    lars_row #(.MAX_COLS(MAX_COLS)) u_body (
        .up   (row_above_reg),
        .mid  (row_mid_reg),
        .dn   (cur_row),
        .cols (eff_cols),
        .row  (body_row)
    );

    lars_row #(.MAX_COLS(MAX_COLS)) u_tail (
        .up   (row_mid_reg),
        .mid  (cur_row),
        .dn   ({MAX_COLS{1'b0}}),
        .cols (eff_cols),
        .row  (tail_row)
    );

    // result beats for this input
    always_comb
    begin
        body_res.cells = ROW_W'(body_row);
        body_res.idx   = r_minus1[IDX_W-1:0];
        body_res.done  = 1'b0;
        tail_res.cells = ROW_W'(tail_row);
        tail_res.idx   = r_ext[IDX_W-1:0];
        tail_res.done  = 1'b1;
    end

    assign push_body = in_acc && (rows_seen_reg != '0);
    assign push_tail = in_acc && last_row;

    // row history and count
    always_comb
    begin
        row_above_next = row_above_reg;
        row_mid_next   = row_mid_reg;
        rows_seen_next = rows_seen_reg;
        if (in_acc)
        begin
            if (last_row)
            begin
                row_above_next = '0;
                row_mid_next   = '0;
                rows_seen_next = '0;
            end
            else
            begin
                row_above_next = row_mid_reg;
                row_mid_next   = cur_row;
                rows_seen_next = r_plus1[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_above_reg <= '0;
            row_mid_reg   <= '0;
            rows_seen_reg <= '0;
        end
        else
        begin
            row_above_reg <= row_above_next;
            row_mid_reg   <= row_mid_next;
            rows_seen_reg <= rows_seen_next;
        end
    end

    // result queue
    lars_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en0   (push_body || push_tail),
        .wr_data0 (push_body ? body_res : tail_res),
        .wr_en1   (push_body && push_tail),
        .wr_data1 (tail_res),
        .pop      (out_valid && !out_stall),
        .rd_data  (head_res),
        .stat     (q_stat)
    );

    assign in_stall        = q_stat.full;
    assign out_valid       = q_stat.has_data;
    assign next_row_cells  = head_res.cells;
    assign out_row_index   = head_res.idx;
    assign generation_done = head_res.done;

    // checks
    `LARS_ASSERT_IMP(a_fresh_gen_clear, clk, rst_n, rows_seen_reg == '0, (row_above_reg == '0) && (row_mid_reg == '0))
    `LARS_ASSERT_NEXT(a_last_restarts, clk, rst_n, in_acc && last_row, rows_seen_reg == '0)
    `LARS_ASSERT_NEXT(a_row_advance, clk, rst_n, in_acc && !last_row, rows_seen_reg == $past(rows_seen_reg) + CNT_W'(1))
    `LARS_ASSERT_IMP(a_stall_needs_data, clk, rst_n, in_stall, out_valid)

endmodule

// File: tb/life_automaton_row_step_tb.sv
module life_automaton_row_step_tb;
    import lars_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 1024;
    localparam int RAND_ROWS  = 1200;
    localparam int CALM_ROWS  = 150;
    localparam int HOLD_CYCLES = 60;
    localparam int HOLD_PHASE = 0;
    localparam int BIG_PHASE  = 1;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic {PLAN_CFG, PLAN_ROW} plan_kind_t;

    // one directed step: a register write or a row, optionally with a known result
    typedef struct {
        plan_kind_t           op;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [ROW_W-1:0]     value;
        logic                 known;
        res_t                 want;
    } plan_step_t;

    // per-row note travelling with the beat: known result for single-row grids
    typedef struct packed {
        logic known;
        res_t want;
    } row_note_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [NROWS_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [ROW_W-1:0]     row_cells;
    logic                 out_valid;
    logic                 out_stall;
    logic [ROW_W-1:0]     next_row_cells;
    logic [IDX_W-1:0]     out_row_index;
    logic                 generation_done;

    // register copies and row state of the predictor
    logic [NROWS_W-1:0] grid_rows_reg = NUM_ROWS_RST;
    logic [NCOLS_W-1:0] grid_cols_reg = NUM_COLS_RST;
    logic [ROW_W-1:0]   held_above    = '0;
    logic [ROW_W-1:0]   held_middle   = '0;
    int                 rows_in_gen   = 0;

    res_t       pending_rows[$];
    row_note_t  row_notes[$];
    plan_step_t directed_plan[$];

    res_t got;
    res_t want;
    row_note_t beat_note;

    int  errors        = 0;
    int  rows_accepted = 0;
    int  results_seen  = 0;
    int  gens_closed   = 0;
    int  cfg_writes    = 0;
    int  gap_pct       = 0;
    bit  calm          = 1'b0;
    bit  hold_req      = 1'b0;

    life_automaton_row_step dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .row_cells       (row_cells),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .next_row_cells  (next_row_cells),
        .out_row_index   (out_row_index),
        .generation_done (generation_done)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // effective sizes: zero counts as one, large counts saturate
    function automatic int rows_in_effect(input logic [NROWS_W-1:0] r);
        int n;
        n = int'(r);
        if (n == 0) n = 1;
        if (n > MAX_ROWS) n = MAX_ROWS;
        return n;
    endfunction

    function automatic int cols_in_effect(input logic [NCOLS_W-1:0] c);
        int n;
        n = int'(c);
        if (n == 0) n = 1;
        if (n > MAX_COLS) n = MAX_COLS;
        return n;
    endfunction

    function automatic int alive_at(input logic [ROW_W-1:0] row, input int c, input int cols);
        if (c < 0 || c >= cols) return 0;
        return int'(row[c]);
    endfunction

    // b3/s23 rule over three rows, columns at or beyond cols stay dead
    function automatic logic [ROW_W-1:0] life_next_row(input logic [ROW_W-1:0] up,
                                                       input logic [ROW_W-1:0] mid,
                                                       input logic [ROW_W-1:0] dn,
                                                       input int cols);
        logic [ROW_W-1:0] res;
        int c;
        int n;
        res = '0;
        for (c = 0; c < cols; c++) begin
            n = alive_at(up, c - 1, cols) + alive_at(up, c, cols) + alive_at(up, c + 1, cols)
              + alive_at(mid, c - 1, cols) + alive_at(mid, c + 1, cols)
              + alive_at(dn, c - 1, cols) + alive_at(dn, c, cols) + alive_at(dn, c + 1, cols);
            if (mid[c] ? (n == 2 || n == 3) : (n == 3))
                res[c] = 1'b1;
        end
        return res;
    endfunction

    // advance the predictor by one accepted row and queue the rows it releases
    task automatic predict_next_rows(input logic [ROW_W-1:0] raw, input row_note_t note);
        int   rows;
        int   cols;
        logic [ROW_W-1:0] cur;
        logic last;
        res_t r;
        rows = rows_in_effect(grid_rows_reg);
        cols = cols_in_effect(grid_cols_reg);
        cur  = (cols >= ROW_W) ? raw : (raw & ((64'd1 << cols) - 64'd1));
        last = (rows_in_gen + 1 >= rows);
        if (rows_in_gen != 0) begin
            r.cells = life_next_row(held_above, held_middle, cur, cols);
            r.idx   = IDX_W'(rows_in_gen - 1);
            r.done  = 1'b0;
            pending_rows.push_back(r);
        end
        if (last) begin
            r.cells = life_next_row(rows_in_gen != 0 ? held_middle : '0, cur, '0, cols);
            r.idx   = IDX_W'(rows_in_gen);
            r.done  = 1'b1;
            pending_rows.push_back(note.known ? note.want : r);
            held_above  = '0;
            held_middle = '0;
            rows_in_gen = 0;
        end else begin
            held_above  = (rows_in_gen != 0) ? held_middle : '0;
            held_middle = cur;
            rows_in_gen = rows_in_gen + 1;
        end
    endtask

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // track register writes and accepted rows
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_NUM_ROWS)
                    grid_rows_reg = cfg_data;
                else
                    grid_cols_reg = cfg_data[NCOLS_W-1:0];
                cfg_writes++;
            end
            if (in_valid && !in_stall) begin
                beat_note = row_notes.pop_front();
                predict_next_rows(row_cells, beat_note);
                rows_accepted++;
            end
        end
    end

    // compare each output beat with the oldest expected row
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            got.cells = next_row_cells;
            got.idx   = out_row_index;
            got.done  = generation_done;
            results_seen++;
            if (pending_rows.size() == 0) begin
                flag_error($sformatf("unexpected beat: cells=%h idx=%0d done=%b",
                                     got.cells, got.idx, got.done));
            end else begin
                want = pending_rows.pop_front();
                if (got.cells !== want.cells || got.idx !== want.idx
                        || got.done !== want.done)
                    flag_error($sformatf("row mismatch: exp cells=%h idx=%0d done=%b, got cells=%h idx=%0d done=%b",
                                         want.cells, want.idx, want.done,
                                         got.cells, got.idx, got.done));
                if (want.done)
                    gens_closed++;
            end
        end
    end

    // receiver: random stall bursts, quiet stretches, and one long hold
    initial begin
        int stall_pct;
        int stretch_left;
        int hold_cnt;
        stall_pct    = 0;
        stretch_left = 0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (stretch_left == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 35;
                endcase
                stretch_left = $urandom_range(30, 150);
            end
            stretch_left--;
            if (hold_req) begin
                out_stall <= 1'b1;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // wait until every expected row has come out, then let the pipe go quiet
    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NROWS_W-1:0] val);
        settle_block();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one row beat, held until taken, then maybe a gap
    task automatic send_row(input logic [ROW_W-1:0] cells, input row_note_t note);
        row_notes.push_back(note);
        in_valid  <= 1'b1;
        row_cells <= cells;
        do
            @(posedge clk);
        while (in_stall);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [NROWS_W-1:0] val);
        plan_step_t s;
        s.op      = PLAN_CFG;
        s.reg_idx = idx;
        s.value   = ROW_W'(val);
        s.known   = 1'b0;
        s.want    = '0;
        directed_plan.push_back(s);
    endtask

    task automatic plan_row(input logic [ROW_W-1:0] cells);
        plan_step_t s;
        s.op      = PLAN_ROW;
        s.reg_idx = '0;
        s.value   = cells;
        s.known   = 1'b0;
        s.want    = '0;
        directed_plan.push_back(s);
    endtask

    // single-row grid: the one result is row 0 and closes the generation
    task automatic plan_row_known(input logic [ROW_W-1:0] cells, input logic [ROW_W-1:0] nxt);
        plan_step_t s;
        s.op         = PLAN_ROW;
        s.reg_idx    = '0;
        s.value      = cells;
        s.known      = 1'b1;
        s.want.cells = nxt;
        s.want.idx   = '0;
        s.want.done  = 1'b1;
        directed_plan.push_back(s);
    endtask

    function automatic logic [ROW_W-1:0] pick_cells();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0, 1: return a;
            2: return a & b;
            3: return a | b;
            4: return a & b & {$urandom, $urandom};
            5: return {61'd0, 3'($urandom)} << $urandom_range(0, 61);
            default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
        endcase
    endfunction

    // time limit
    initial begin
        #8ms;
        $display("life_automaton_row_step_tb NOT OK");
        $finish;
    end

    // stimulus
    initial begin
        int i;
        int k;
        int phase;
        int rand_rows;
        int eff;
        int count;
        logic [NROWS_W-1:0] rows_w;
        logic [NCOLS_W-1:0] cols_w;
        row_note_t blank_note;
        row_note_t n;

        blank_note = '0;
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        row_cells  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-row grid, full width
        plan_cfg(REG_NUM_ROWS, 11'd1);
        plan_row_known(64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE);
        plan_row_known(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
        plan_row_known(64'h0000_0000_0000_0007, 64'h0000_0000_0000_0002);
        plan_row_known(64'h8000_0000_0000_0001, 64'h0000_0000_0000_0000);
        // zero columns act as one, dead columns ignored
        plan_cfg(REG_NUM_COLS, 11'd0);
        plan_row_known(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
        plan_cfg(REG_NUM_COLS, 11'd5);
        plan_row_known(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_000E);
        // oversize columns saturate, zero rows act as one
        plan_cfg(REG_NUM_COLS, 11'd127);
        plan_cfg(REG_NUM_ROWS, 11'd0);
        plan_row_known(64'hE000_0000_0000_0000, 64'h4000_0000_0000_0000);
        // vertical blinker on three rows
        plan_cfg(REG_NUM_ROWS, 11'd3);
        plan_row(64'h0000_0000_0000_0002);
        plan_row(64'h0000_0000_0000_0002);
        plan_row(64'h0000_0000_0000_0002);
        // corner blocks on a two-row grid
        plan_cfg(REG_NUM_ROWS, 11'd2);
        plan_row(64'hC000_0000_0000_0003);
        plan_row(64'hC000_0000_0000_0003);
        // row count lowered below the rows already taken
        plan_cfg(REG_NUM_ROWS, 11'd5);
        plan_row(64'hFFFF_FFFF_FFFF_FFFF);
        plan_row(64'hA5A5_A5A5_A5A5_A5A5);
        plan_row(64'h5A5A_5A5A_5A5A_5A5A);
        plan_cfg(REG_NUM_ROWS, 11'd2);
        plan_row(64'h0F0F_0F0F_0F0F_0F0F);
        // fully alive grid
        plan_cfg(REG_NUM_ROWS, 11'd4);
        for (i = 0; i < 4; i++)
            plan_row(64'hFFFF_FFFF_FFFF_FFFF);

        gap_pct = 20;
        for (i = 0; i < directed_plan.size(); i++) begin
            if (directed_plan[i].op == PLAN_CFG) begin
                write_reg(directed_plan[i].reg_idx, NROWS_W'(directed_plan[i].value));
            end else begin
                n.known = directed_plan[i].known;
                n.want  = directed_plan[i].want;
                send_row(directed_plan[i].value, n);
            end
        end

        // random generations with random sizes
        rows_w    = 11'd4;
        cols_w    = 7'd64;
        phase     = 0;
        rand_rows = 0;
        while (rand_rows < RAND_ROWS) begin
            if (phase == BIG_PHASE) begin
                rows_w = 11'h7FF;
                cols_w = 7'($urandom_range(3, 64));
            end else if (phase == HOLD_PHASE) begin
                rows_w = 11'd8;
                cols_w = 7'd64;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1: rows_w = 11'($urandom_range(13, 80));
                    2: rows_w = 11'($urandom_range(0, 1));
                    default: rows_w = 11'($urandom_range(2, 12));
                endcase
                case ($urandom_range(0, 9))
                    0: cols_w = 7'($urandom_range(0, 2));
                    1: cols_w = 7'd64;
                    2: cols_w = 7'($urandom_range(65, 127));
                    default: cols_w = 7'($urandom_range(3, 64));
                endcase
            end
            if (phase == BIG_PHASE || phase == HOLD_PHASE || $urandom_range(0, 5) != 0)
                write_reg(REG_NUM_ROWS, rows_w);
            else
                rows_w = grid_rows_reg;
            if (phase == BIG_PHASE || phase == HOLD_PHASE || $urandom_range(0, 5) != 0)
                write_reg(REG_NUM_COLS, {4'($urandom), cols_w});

            eff = rows_in_effect(rows_w);
            if (phase == BIG_PHASE)
                count = eff;
            else if (phase == HOLD_PHASE)
                count = 3 * eff;
            else
                count = $urandom_range(1, 3) * eff;
            if (phase != BIG_PHASE && eff > 1 && $urandom_range(0, 4) == 0)
                count += $urandom_range(1, eff - 1);

            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 35;
            endcase
            if (phase == HOLD_PHASE)
                gap_pct = 0;

            for (k = 0; k < count; k++) begin
                if (phase == HOLD_PHASE && k == 4)
                    hold_req = 1'b1;
                if (phase != BIG_PHASE && rand_rows >= RAND_ROWS - CALM_ROWS) begin
                    calm    = 1'b1;
                    gap_pct = 0;
                end
                send_row(pick_cells(), blank_note);
                rand_rows++;
            end
            phase++;
        end

        // drain and report
        settle_block();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_rows.size() != 0)
            flag_error($sformatf("%0d expected rows never came out", pending_rows.size()));
        $display("covered %0d row beats in, %0d row beats out, %0d generations closed",
                 rows_accepted, results_seen, gens_closed);
        $display("%0d register writes; grids from 1 to %0d rows, 1 to %0d columns; %0d errors",
                 cfg_writes, MAX_ROWS, MAX_COLS, errors);
        if (errors == 0)
            $display("life_automaton_row_step_tb OK");
        else
            $display("life_automaton_row_step_tb NOT OK");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/lars_pkg.sv
src/lars_cell.sv
src/lars_row.sv
src/lars_queue.sv
src/life_automaton_row_step.sv
tb/life_automaton_row_step_tb.sv
